>>> rtl/bss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bss_pkg: shared types for the bounded sequence store
// Operation codes, controller states and the command/status bundles that
// link the controller and the datapath.
// ----------------------------------------------------------------------------
package bss_pkg;

  // Operation codes carried on the input beat.
  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  // Which word the memory read port fetches, relative to the walk index.
  typedef enum logic [1:0] {
    RD_AT    = 2'd0,
    RD_BELOW = 2'd1,
    RD_ABOVE = 2'd2
  } rd_mode_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_P_TEST,
    ST_P_WR,
    ST_T_RD0,
    ST_T_GRAB,
    ST_T_TEST,
    ST_T_WR,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     init_place;
    logic     init_take;
    rd_mode_t rd_mode;
    logic     wr_shift_up;
    logic     wr_put;
    logic     grab;
    logic     wr_shift_down;
    logic     finish_take;
    logic     do_clear;
    logic     load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_place;
    logic is_take;
    logic is_clear;
    logic place_ok;
    logic take_ok;
    logic idx_gt_pos;
    logic more_take;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/bounded_sequence_store.sv
`default_nettype none
// Clear, refused and unused operations do no walk; a push or insert shifts the words from
// count - 1 down to position up one, and a pop or erase shifts the words above position
// down one, with count taken before the operation.
// One beat is in work at a time; the next input beat is taken as early as the result beat,
// and a shift moves one word at a time through the single memory read port.
// Reset clears the occupancy and the controller; the element memory is not cleared.
// ----------------------------------------------------------------------------
// bounded_sequence_store: ordered store of up to DEPTH signed words
// Push and pop at either end, insert and erase at a position, and clear,
// with one result beat per input beat.
// ----------------------------------------------------------------------------
module bounded_sequence_store #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic [4:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] removed_value,
  output logic               success,
  output logic [4:0]         count
);

  bss_pkg::cmd_t    cmd;
  bss_pkg::status_t status;

  // Operation sequencer.
  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Element memory and counters.
  bss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .operation     (operation),
    .position      (position),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .removed_value (removed_value),
    .success       (success),
    .count         (count)
  );

endmodule
`default_nettype wire

>>> rtl/bss_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bss_datapath: element memory, occupancy and walk index
// Holds the captured beat, the word memory with one registered read port,
// the occupancy counter, the shift walk index and the output register.
// ----------------------------------------------------------------------------
module bss_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  bss_pkg::cmd_t       cmd,
  output bss_pkg::status_t    status,
  input  logic [2:0]          operation,
  input  logic [4:0]          position,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  removed_value,
  output logic                success,
  output logic [4:0]          count
);

  localparam int OW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int PW = (OW > 5) ? OW : 5;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  // Captured beat.
  logic [2:0]  op;
  logic [4:0]  pos;
  logic [31:0] val;

  // Store state and walk registers.
  logic [OW-1:0] occ;
  logic [PW-1:0] idx;
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata;
  logic          res_ok;
  logic [31:0]   res_removed;

  logic [PW-1:0] occ_ext;
  logic [PW-1:0] eff_pos;
  logic [PW-1:0] rd_idx;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;

  assign occ_ext = PW'(occ);

  // Effective position for each operation.
  always_comb begin
    case (op) inside
      bss_pkg::OP_APPEND:    eff_pos = occ_ext;
      bss_pkg::OP_POP_BACK:  eff_pos = occ_ext - PW'(1);
      bss_pkg::OP_INSERT,
      bss_pkg::OP_ERASE:     eff_pos = PW'(pos);
      default:               eff_pos = '0;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    status.is_place   = (op == bss_pkg::OP_APPEND) || (op == bss_pkg::OP_PUSH_FRONT) ||
                        (op == bss_pkg::OP_INSERT);
    status.is_take    = (op == bss_pkg::OP_POP_BACK) || (op == bss_pkg::OP_POP_FRONT) ||
                        (op == bss_pkg::OP_ERASE);
    status.is_clear   = (op == bss_pkg::OP_CLEAR);
    status.place_ok   = (occ_ext < DEPTH_P) && (eff_pos <= occ_ext);
    status.take_ok    = (occ_ext != '0) && (eff_pos < occ_ext);
    status.idx_gt_pos = (idx > eff_pos);
    status.more_take  = ((idx + PW'(1)) < occ_ext);
    status.out_free   = !out_valid || !out_stall;
  end

  // Read address relative to the walk index.
  always_comb begin
    unique case (cmd.rd_mode)
      bss_pkg::RD_BELOW: rd_idx = idx - PW'(1);
      bss_pkg::RD_ABOVE: rd_idx = idx + PW'(1);
      default:           rd_idx = idx;
    endcase
  end
  assign rd_addr = rd_idx[AW-1:0];

  // Single write port: shifted word or the new word.
  assign wr_en   = cmd.wr_shift_up || cmd.wr_shift_down || cmd.wr_put;
  assign wr_addr = cmd.wr_put ? eff_pos[AW-1:0] : idx[AW-1:0];
  assign wr_data = cmd.wr_put ? val : rdata;

  // Element memory with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Captured beat and result payload.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op          <= operation;
      pos         <= position;
      val         <= value;
      res_ok      <= 1'b0;
      res_removed <= '0;
    end
    if (cmd.init_place) begin
      idx <= occ_ext;
    end
    if (cmd.init_take) begin
      idx <= eff_pos;
    end
    if (cmd.wr_shift_up) begin
      idx <= idx - PW'(1);
    end
    if (cmd.wr_shift_down) begin
      idx <= idx + PW'(1);
    end
    if (cmd.grab) begin
      res_removed <= rdata;
    end
    if (cmd.wr_put || cmd.finish_take || cmd.do_clear) begin
      res_ok <= 1'b1;
    end
    if (cmd.load_out) begin
      removed_value <= res_removed;
      success       <= res_ok;
      count         <= occ_ext[4:0];
    end
  end

  // Occupancy counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.do_clear) begin
        occ <= '0;
      end else if (cmd.wr_put) begin
        occ <= occ + OW'(1);
      end else if (cmd.finish_take) begin
        occ <= occ - OW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/bss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bss_ctrl: operation sequencer
// Walks each operation through check, element shift and result hand-off,
// issuing one command bundle to the datapath per cycle.
// ----------------------------------------------------------------------------
module bss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bss_pkg::status_t  status,
  output bss_pkg::cmd_t     cmd
);

  bss_pkg::state_t state;
  bss_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      bss_pkg::ST_IDLE: begin
        if (in_valid) state_next = bss_pkg::ST_CHECK;
      end
      bss_pkg::ST_CHECK: begin
        if (status.is_place && status.place_ok) begin
          state_next = bss_pkg::ST_P_TEST;
        end else if (status.is_take && status.take_ok) begin
          state_next = bss_pkg::ST_T_RD0;
        end else begin
          state_next = bss_pkg::ST_DONE;
        end
      end
      bss_pkg::ST_P_TEST: begin
        state_next = status.idx_gt_pos ? bss_pkg::ST_P_WR : bss_pkg::ST_DONE;
      end
      bss_pkg::ST_P_WR:   state_next = bss_pkg::ST_P_TEST;
      bss_pkg::ST_T_RD0:  state_next = bss_pkg::ST_T_GRAB;
      bss_pkg::ST_T_GRAB: state_next = bss_pkg::ST_T_TEST;
      bss_pkg::ST_T_TEST: begin
        state_next = status.more_take ? bss_pkg::ST_T_WR : bss_pkg::ST_DONE;
      end
      bss_pkg::ST_T_WR:   state_next = bss_pkg::ST_T_TEST;
      bss_pkg::ST_DONE: begin
        if (status.out_free) state_next = bss_pkg::ST_IDLE;
      end
      default:            state_next = bss_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    cmd.rd_mode = bss_pkg::RD_AT;
    in_stall = 1'b1;
    unique case (state)
      bss_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      bss_pkg::ST_CHECK: begin
        cmd.init_place = status.is_place && status.place_ok;
        cmd.init_take  = status.is_take && status.take_ok;
        cmd.do_clear   = status.is_clear;
      end
      bss_pkg::ST_P_TEST: begin
        cmd.rd_mode = bss_pkg::RD_BELOW;
        cmd.wr_put  = !status.idx_gt_pos;
      end
      bss_pkg::ST_P_WR:   cmd.wr_shift_up = 1'b1;
      bss_pkg::ST_T_RD0:  cmd.rd_mode = bss_pkg::RD_AT;
      bss_pkg::ST_T_GRAB: cmd.grab = 1'b1;
      bss_pkg::ST_T_TEST: begin
        cmd.rd_mode     = bss_pkg::RD_ABOVE;
        cmd.finish_take = !status.more_take;
      end
      bss_pkg::ST_T_WR:   cmd.wr_shift_down = 1'b1;
      bss_pkg::ST_DONE:   cmd.load_out = status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> test/tb_bounded_sequence_store.sv
// ----------------------------------------------------------------------------
// tb_bounded_sequence_store: self-checking testbench for the sequence store
// A scoreboard class keeps its own copy of the stored words and predicts the
// result of every accepted operation. Directed beats cover the empty and full
// store, positions past the end, extreme words and every operation code.
// Random bursts then sweep the fill level up and down while the result side
// stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
localparam int STORE_DEPTH = 16;
// The one operation code that the block leaves unused.
localparam logic [2:0] OP_UNUSED = 3'd7;

typedef struct {
  logic signed [31:0] removed;
  logic               ok;
  logic [4:0]         cnt;
} store_result_t;

class store_tracker;
  logic signed [31:0] words[STORE_DEPTH];
  int unsigned        fill;
  store_result_t      awaited[$];
  int unsigned        failures;

  function new();
    fill     = 0;
    failures = 0;
  endfunction

  // Put a word at index at; the words at and above it move up one.
  function bit place(int unsigned at, logic signed [31:0] w);
    int unsigned k;
    if (fill >= STORE_DEPTH || at > fill) return 0;
    for (k = fill; k > at; k--) words[k] = words[k-1];
    words[at] = w;
    fill++;
    return 1;
  endfunction

  // Take out the word at index at; the words above it move down one.
  function bit take(int unsigned at, output logic signed [31:0] w);
    int unsigned k;
    w = 0;
    if (at >= fill) return 0;
    w = words[at];
    for (k = at; k + 1 < fill; k++) words[k] = words[k+1];
    fill--;
    return 1;
  endfunction

  // Apply one accepted operation to the shadow store and queue its result.
  function void note_request(logic [2:0] op, logic [4:0] pos, logic signed [31:0] val);
    store_result_t r;
    r.removed = 0;
    r.ok      = 0;
    case (op)
      bss_pkg::OP_APPEND:     r.ok = place(fill, val);
      bss_pkg::OP_POP_BACK:   if (fill > 0) r.ok = take(fill - 1, r.removed);
      bss_pkg::OP_PUSH_FRONT: r.ok = place(0, val);
      bss_pkg::OP_POP_FRONT:  r.ok = take(0, r.removed);
      bss_pkg::OP_INSERT:     r.ok = place(pos, val);
      bss_pkg::OP_ERASE:      r.ok = take(pos, r.removed);
      bss_pkg::OP_CLEAR: begin
        fill = 0;
        r.ok = 1;
      end
      default: ;
    endcase
    if (!r.ok) r.removed = 0;
    r.cnt = fill[4:0];
    awaited = {awaited, r};
  endfunction

  function void report(longint stamp, string what, longint exp_v, longint act_v);
    failures++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", stamp, what, exp_v, act_v);
  endfunction

  // Compare one accepted result beat with the oldest prediction.
  function void check_response(longint stamp, logic signed [31:0] rv, logic ok,
                               logic [4:0] cnt);
    store_result_t r;
    if (awaited.size() == 0) begin
      failures++;
      $display("%0t ns: result beat with none expected, removed %0d success %0d count %0d",
               stamp, rv, ok, cnt);
      return;
    end
    r = awaited.pop_front();
    if (rv !== r.removed) report(stamp, "removed_value", r.removed, rv);
    if (ok !== r.ok) report(stamp, "success", r.ok, ok);
    if (cnt !== r.cnt) report(stamp, "count", r.cnt, cnt);
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction
endclass

module tb_bounded_sequence_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1700;
  localparam int CYCLE_LIMIT  = 1000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         operation = bss_pkg::OP_APPEND;
  logic [4:0]         position = 5'd0;
  logic signed [31:0] value = 32'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] removed_value;
  logic               success;
  logic [4:0]         count;

  store_tracker tracker = new();
  int unsigned  cycle_count = 0;

  bounded_sequence_store #(.DEPTH(STORE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .removed_value(removed_value),
    .success(success),
    .count(count)
  );

  // Free-running 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_bounded_sequence_store failed");
      $finish;
    end
  end

  // Result monitor: every accepted beat goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_response($time, removed_value, success, count);
  end

  // Offer one beat and hold it until the block takes it. The valid is left
  // high so that a following beat can go out back to back.
  task automatic send_beat(logic [2:0] op, logic [4:0] pos, logic signed [31:0] val);
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(op, pos, val);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly random words, with the extremes and small values mixed in.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom();
    endcase
  endfunction

  // Result side: stall pattern that changes mode from span to span, with
  // one long hold-off so that the block backs up and stalls its input.
  initial begin : result_side
    int  mode;
    int  span;
    int  phase;
    phase = 0;
    while (rst) @(posedge clk);
    forever begin
      phase++;
      if (phase == 8) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus: reset, directed beats, random bursts, then drain.
  initial begin : stimulus
    int          sent;
    int          burst;
    int          roll;
    int          i;
    bit          growing;
    logic [2:0]  op;
    logic [4:0]  pos;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Refusals on an empty store and the unused code.
    send_beat(bss_pkg::OP_POP_BACK, 5'd0, 32'sd5);
    send_beat(bss_pkg::OP_POP_FRONT, 5'd0, 32'sd5);
    send_beat(bss_pkg::OP_ERASE, 5'd0, 32'sd5);
    send_beat(bss_pkg::OP_INSERT, 5'd1, 32'sd5);
    send_beat(OP_UNUSED, 5'd31, -32'sd1);

    // Fill to the top with extreme words at both ends and in the middle.
    send_beat(bss_pkg::OP_APPEND, 5'd0, 32'sh7FFFFFFF);
    send_beat(bss_pkg::OP_PUSH_FRONT, 5'd0, 32'sh80000000);
    send_beat(bss_pkg::OP_INSERT, 5'd1, -32'sd1);
    send_beat(bss_pkg::OP_INSERT, 5'd3, 32'sd0);
    for (i = 4; i < STORE_DEPTH; i++)
      send_beat(bss_pkg::OP_APPEND, 5'd0, pick_word());

    // Refusals on a full store, erase past the end, then drain and clear.
    send_beat(bss_pkg::OP_APPEND, 5'd0, 32'sd9);
    send_beat(bss_pkg::OP_INSERT, 5'd16, 32'sd9);
    send_beat(bss_pkg::OP_ERASE, 5'd16, 32'sd0);
    send_beat(bss_pkg::OP_ERASE, 5'd15, 32'sd0);
    send_beat(bss_pkg::OP_POP_FRONT, 5'd0, 32'sd0);
    send_beat(bss_pkg::OP_POP_BACK, 5'd0, 32'sd0);
    send_beat(bss_pkg::OP_CLEAR, 5'd0, 32'sd0);

    // Random bursts that sweep the fill level between empty and full.
    sent    = 0;
    growing = 1'b1;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < RANDOM_BEATS) begin
        if (tracker.fill >= STORE_DEPTH) growing = 1'b0;
        else if (tracker.fill == 0) growing = 1'b1;
        roll = $urandom_range(0, 99);
        pos  = 5'd0;
        if (roll < 2) begin
          op = bss_pkg::OP_CLEAR;
        end else if (roll < 3) begin
          op = OP_UNUSED;
          pos = 5'($urandom_range(0, 31));
        end else if (roll < 13) begin
          // Noise: any used operation code at any position from 0 to 16.
          op  = 3'($urandom_range(0, 6));
          pos = 5'($urandom_range(0, 16));
        end else if (growing == ($urandom_range(0, 9) < 7)) begin
          case ($urandom_range(0, 2))
            0: op = bss_pkg::OP_APPEND;
            1: op = bss_pkg::OP_PUSH_FRONT;
            default: begin
              op  = bss_pkg::OP_INSERT;
              pos = 5'($urandom_range(0, tracker.fill));
            end
          endcase
        end else begin
          case ($urandom_range(0, 2))
            0: op = bss_pkg::OP_POP_BACK;
            1: op = bss_pkg::OP_POP_FRONT;
            default: begin
              op  = bss_pkg::OP_ERASE;
              pos = (tracker.fill > 0) ? 5'($urandom_range(0, tracker.fill - 1)) : 5'd0;
            end
          endcase
        end
        send_beat(op, pos, pick_word());
        if (op != OP_UNUSED) sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    // Drain, then allow the longest operation time for stray beats.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (tracker.failures == 0) begin
      $display("tb_bounded_sequence_store passed");
    end else begin
      $display("tb_bounded_sequence_store failed");
    end
    $finish;
  end

endmodule
